### src/vsa_pkg.sv
// Shared constants and types for the voice slot allocator.
// No dependencies; compiled first.
package vsa_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LIM_W   = $clog2(SLOTS + 1);
	localparam int VOICE_W = 4;
	localparam int REQ_W   = 8;
	localparam int STAMP_W = 64;
	localparam int MV_W    = 5;
	localparam int ENTRY_W = REQ_W + STAMP_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [MV_W-1:0] MV_RESET = MV_W'(SLOTS);

	// register indexes
	localparam logic [PADDR_W-3:0] REG_MAX_VOICES = '0;

	// opcodes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [VOICE_W-1:0] voice_t;
	typedef logic [REQ_W-1:0]   req_id_t;
	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [MV_W-1:0]    max_voices_t;
	typedef logic [LIM_W-1:0]   lim_t;

	typedef struct packed {
		req_id_t owner;
		stamp_t  stamp;
	} entry_t;

endpackage

### src/vsa_if.sv
// Request and response channel interfaces of the voice slot allocator.
// Depends on vsa_pkg.
interface vsa_req_if;
	import vsa_pkg::*;

	logic   valid;
	logic   ready;
	logic   opcode;
	req_id_t requester;
	voice_t release_voice;

	modport source (output valid, output opcode, output requester, output release_voice,
		input ready);
	modport sink (input valid, input opcode, input requester, input release_voice,
		output ready);
endinterface

interface vsa_rsp_if;
	import vsa_pkg::*;

	logic    valid;
	logic    ready;
	voice_t  voice;
	logic    granted;
	logic    evicted;
	req_id_t evicted_requester;

	modport source (output valid, output voice, output granted, output evicted,
		output evicted_requester, input ready);
	modport sink (input valid, input voice, input granted, input evicted,
		input evicted_requester, output ready);
endinterface

### src/vsa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/vsa_cfg.sv
// APB-style configuration register block (max_voices).
// Depends on vsa_pkg.
module vsa_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [vsa_pkg::PADDR_W-1:0] paddr,
	input  logic [vsa_pkg::PDATA_W-1:0] pwdata,
	output logic [vsa_pkg::PDATA_W-1:0] prdata,
	output logic                   pready,
	output vsa_pkg::max_voices_t   max_voices
);
	import vsa_pkg::*;

	max_voices_t mv_q;
	logic        sel_mv;

	assign sel_mv     = paddr[PADDR_W-1:2] == REG_MAX_VOICES;
	assign pready     = 1'b1;
	assign max_voices = mv_q;
	assign prdata     = sel_mv ? PDATA_W'(mv_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= MV_RESET;
		end else if (psel && penable && pwrite && pready && sel_mv) begin
			mv_q <= pwdata[MV_W-1:0];
		end
	end
endmodule

### src/vsa_core.sv
// Allocator sequencer: busy bits, stamp counter, oldest-stamp scan over the slot RAM.
// Depends on vsa_pkg and vsa_if; owner and stamp live in an external vsa_ram.
module vsa_core (
	input  logic                 clk,
	input  logic                 arst_n,
	vsa_req_if.sink              req,
	vsa_rsp_if.source            rsp,
	input  vsa_pkg::max_voices_t max_voices,
	output vsa_pkg::slot_t       ram_raddr,
	input  logic [vsa_pkg::ENTRY_W-1:0] ram_rdata,
	output logic                 ram_we,
	output vsa_pkg::slot_t       ram_waddr,
	output logic [vsa_pkg::ENTRY_W-1:0] ram_wdata
);
	import vsa_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_RELRD = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]       state_q;
	logic [SLOTS-1:0] busy_q;
	stamp_t           stamp_q;
	lim_t             scan_cnt_q;
	logic             pend_s1;
	logic             have_q;
	logic             fin_alloc_q;
	logic             fin_free_q;
	logic             rsp_valid_q;

	slot_t   idx_s1;
	slot_t   best_idx_q;
	stamp_t  best_stamp_q;
	req_id_t best_owner_q;
	req_id_t req_q;
	voice_t  rel_q;
	slot_t   fin_idx_q;
	voice_t  fin_voice_q;
	logic    fin_granted_q;
	logic    fin_evicted_q;
	req_id_t fin_evreq_q;
	voice_t  rsp_voice_q;
	logic    rsp_granted_q;
	logic    rsp_evicted_q;
	req_id_t rsp_evreq_q;

	lim_t             lim;
	logic [SLOTS-1:0] lim_mask;
	logic [SLOTS-1:0] free_vec;
	logic             free_found;
	slot_t            free_idx;
	entry_t           rd_entry;
	logic             req_fire;
	logic             out_free;
	logic             fin_fire;
	logic             scan_issue;
	logic             scan_done;
	logic             better;
	logic             rel_grant;

	always_comb begin
		if (max_voices == '0) begin
			lim = LIM_W'(1);
		end else if (int'(max_voices) > SLOTS) begin
			lim = LIM_W'(SLOTS);
		end else begin
			lim = LIM_W'(max_voices);
		end
		for (int i = 0; i < SLOTS; i++) begin
			lim_mask[i] = i < int'(lim);
		end
		free_vec   = ~busy_q & lim_mask;
		free_found = |free_vec;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign req.ready  = state_q == ST_IDLE;
	assign req_fire   = req.valid && req.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign fin_fire   = state_q == ST_FIN && out_free;
	assign scan_issue = state_q == ST_SCAN && scan_cnt_q < lim;
	assign scan_done  = !pend_s1 && !scan_issue;
	assign rd_entry   = entry_t'(ram_rdata);
	assign better     = !have_q || rd_entry.stamp < best_stamp_q;
	assign rel_grant  = int'(rel_q) < SLOTS && busy_q[fin_idx_q] && rd_entry.owner == req_q;

	assign ram_raddr = (state_q == ST_IDLE) ? SLOT_W'(req.release_voice)
		: scan_cnt_q[SLOT_W-1:0];
	assign ram_we    = fin_fire && fin_alloc_q;
	assign ram_waddr = fin_idx_q;
	assign ram_wdata = ENTRY_W'({req_q, stamp_q});

	assign rsp.valid             = rsp_valid_q;
	assign rsp.voice             = rsp_voice_q;
	assign rsp.granted           = rsp_granted_q;
	assign rsp.evicted           = rsp_evicted_q;
	assign rsp.evicted_requester = rsp_evreq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= '0;
			stamp_q     <= '0;
			scan_cnt_q  <= '0;
			pend_s1     <= 1'b0;
			have_q      <= 1'b0;
			fin_alloc_q <= 1'b0;
			fin_free_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= fin_fire || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.opcode == OP_ALLOC) begin
							if (free_found) begin
								state_q     <= ST_FIN;
								fin_alloc_q <= 1'b1;
								fin_free_q  <= 1'b0;
							end else begin
								state_q    <= ST_SCAN;
								scan_cnt_q <= '0;
								have_q     <= 1'b0;
								pend_s1    <= 1'b0;
							end
						end else begin
							state_q <= ST_RELRD;
						end
					end
				end
				ST_SCAN: begin
					if (pend_s1 && better) begin
						have_q <= 1'b1;
					end
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + LIM_W'(1);
					end
					if (scan_done) begin
						state_q     <= ST_FIN;
						fin_alloc_q <= 1'b1;
						fin_free_q  <= 1'b0;
					end
				end
				ST_RELRD: begin
					state_q     <= ST_FIN;
					fin_alloc_q <= 1'b0;
					fin_free_q  <= rel_grant;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (fin_alloc_q) begin
							busy_q[fin_idx_q] <= 1'b1;
							stamp_q           <= stamp_q + STAMP_W'(1);
						end
						if (fin_free_q) begin
							busy_q[fin_idx_q] <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					req_q         <= req.requester;
					rel_q         <= req.release_voice;
					fin_evicted_q <= 1'b0;
					fin_evreq_q   <= '0;
					if (req.opcode == OP_ALLOC) begin
						fin_idx_q     <= free_idx;
						fin_voice_q   <= VOICE_W'(free_idx);
						fin_granted_q <= 1'b1;
					end else begin
						fin_idx_q   <= SLOT_W'(req.release_voice);
						fin_voice_q <= req.release_voice;
					end
				end
			end
			ST_SCAN: begin
				idx_s1 <= scan_cnt_q[SLOT_W-1:0];
				if (pend_s1 && better) begin
					best_idx_q   <= idx_s1;
					best_stamp_q <= rd_entry.stamp;
					best_owner_q <= rd_entry.owner;
				end
				if (scan_done) begin
					fin_idx_q     <= best_idx_q;
					fin_voice_q   <= VOICE_W'(best_idx_q);
					fin_granted_q <= 1'b1;
					fin_evicted_q <= 1'b1;
					fin_evreq_q   <= best_owner_q;
				end
			end
			ST_RELRD: begin
				fin_granted_q <= rel_grant;
			end
			ST_FIN: begin
				if (out_free) begin
					rsp_voice_q   <= fin_voice_q;
					rsp_granted_q <= fin_granted_q;
					rsp_evicted_q <= fin_evicted_q;
					rsp_evreq_q   <= fin_evreq_q;
				end
			end
			default: ;
		endcase
	end

	// steal scan only runs with every active slot occupied
	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> &(busy_q | ~lim_mask))
		else $error("scan started with a free active slot");

	a_stamp_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		!(fin_fire && fin_alloc_q) |=> $stable(stamp_q))
		else $error("stamp advanced without an allocation");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && fin_alloc_q |=> busy_q[$past(fin_idx_q)])
		else $error("allocated slot not marked busy");

	a_free_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && fin_free_q |=> !busy_q[$past(fin_idx_q)])
		else $error("released slot still busy");
endmodule

### src/voice_slot_allocator_oldest_steal.sv
// Voice slot allocator with oldest-voice stealing: top level.
// Depends on vsa_pkg, vsa_if, vsa_ram, vsa_cfg and vsa_core.
//
// Usage:
//   req carries one transaction per note event: opcode allocate or release,
//   the requester id and, for a release, the slot. rsp returns exactly one
//   transaction per request: the slot, granted, evicted and the evicted owner.
//   max_voices is written over the APB port at address 0 while idle.
// Sequence (states from the accepting state IDLE until the next request is taken):
//   allocate with a free active slot: FIN
//   release: RELRD, then FIN (one RAM read for the owner check)
//   allocate with all active slots busy: SCAN, then FIN; the stamp scan reads
//   the slots below the limit, one slot per cycle from the owner/stamp RAM port.
//   The response becomes valid in the same cycle as req.ready returns high.
// One request is processed at a time; req.ready is high while none is active.
// A response waits in the output register if rsp is stalled; the next request
// can still be accepted and completes as soon as that register is taken.
// Reset clears busy bits and the stamp counter and sets max_voices to 16.
// Owner and stamp RAM contents need no clearing.
module voice_slot_allocator_oldest_steal (
	input  logic                        clk,
	input  logic                        arst_n,
	vsa_req_if.sink                     req,
	vsa_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vsa_pkg::PADDR_W-1:0] paddr,
	input  logic [vsa_pkg::PDATA_W-1:0] pwdata,
	output logic [vsa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import vsa_pkg::*;

	max_voices_t        max_voices;
	slot_t              ram_raddr;
	slot_t              ram_waddr;
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	vsa_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.max_voices (max_voices)
	);

	vsa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	vsa_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.max_voices (max_voices),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);
endmodule
